// ===== design/meco_pkg.sv =====
`timescale 1ns / 1ps
package meco_pkg;

  // Default sizes
  localparam int NODES_DEF = 4096;
  localparam int EDGES_DEF = 8192;
  localparam int TRIS_DEF  = 4096;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 13;
  localparam int NODE_W  = 13;
  localparam int TRI_W   = 13;
  localparam int VTX_W   = 14;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int STAT_W  = 2;
  localparam int TAG_W   = 8;
  localparam int CNT_W   = 2;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [MODE_W-1:0] {
    MODE_NODE   = 2'd0,
    MODE_EDGE   = 2'd1,
    MODE_REPORT = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTRI    = 2'd1,
    ST_NOCORNER = 2'd2,
    ST_OVF      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_C_RD, S_C_WR, S_E_DAT, S_T_RD, S_T_DAT,
    S_XA, S_XB, S_XV, S_XL, S_MUL, S_CMP, S_OUT
  } st_t;

  // One queued command
  typedef struct packed {
    mode_t                     kind;
    logic [IDX_W-1:0]          edge_index;
    logic [NODE_W-1:0]         node_number;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [NODE_W-1:0]         na;
    logic [NODE_W-1:0]         nb;
    logic signed [TRI_W-1:0]   ta;
    logic signed [TRI_W-1:0]   tb;
  } cmd_t;

  // Queue head towards the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Back end control towards the front end
  typedef struct packed {
    logic pop;
    logic ready_en;
  } bk_ctl_t;

  // Stored edge
  typedef struct packed {
    logic [NODE_W-1:0]       na;
    logic [NODE_W-1:0]       nb;
    logic signed [TRI_W-1:0] ta;
    logic signed [TRI_W-1:0] tb;
  } erec_t;

  // Stored corner list with clear epoch
  typedef struct packed {
    logic [TAG_W-1:0]             tag;
    logic [CNT_W-1:0]             cnt;
    logic [2:0][NODE_W-1:0]       c;
  } crec_t;

  typedef struct packed {
    logic                   ovf;
    logic [CNT_W-1:0]       cnt;
    logic [2:0][NODE_W-1:0] c;
  } corner_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] v;
  } opp_t;

  // Add node n to a corner list unless present; a fourth corner flags overflow
  function automatic corner_t add_corner(corner_t cur, logic [NODE_W-1:0] n);
    corner_t r;
    logic    hit;
    r   = cur;
    hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ((CNT_W'(k) < cur.cnt) && (cur.c[k] == n)) hit = 1'b1;
    end
    if (!hit) begin
      if (cur.cnt == 2'd3) begin
        r.ovf = 1'b1;
      end else begin
        r.c[cur.cnt[1:0]] = n;
        r.cnt             = cur.cnt + 2'd1;
      end
    end
    return r;
  endfunction

  // Corner opposite edge (a, b); c holds zero beyond the count
  function automatic opp_t opposite(logic [2:0][NODE_W-1:0] c,
                                    logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    opp_t r;
    r.found = 1'b1;
    if (a == c[0])      r.v = (b == c[1]) ? c[2] : c[1];
    else if (a == c[1]) r.v = (b == c[0]) ? c[2] : c[0];
    else if (a == c[2]) r.v = (b == c[0]) ? c[1] : c[0];
    else begin
      r.found = 1'b0;
      r.v     = '0;
    end
    return r;
  endfunction

endpackage

// ===== design/meco_ram.sv =====
`timescale 1ns / 1ps
module meco_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                     rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== design/meco_front.sv =====
`timescale 1ns / 1ps
module meco_front #(
  parameter int NODES = meco_pkg::NODES_DEF,
  parameter int EDGES = meco_pkg::EDGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [meco_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [meco_pkg::MODE_W-1:0]      in_tuser,
  output meco_pkg::q_head_t                q,
  input  meco_pkg::bk_ctl_t                ctl
);
  meco_pkg::cmd_t   mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;
  meco_pkg::cmd_t   cmd;
  logic             keep, push;

  // Unpack and classify the incoming transaction
  always_comb begin
    cmd.kind        = meco_pkg::mode_t'(in_tuser);
    cmd.edge_index  = in_tdata[12:0];
    cmd.node_number = in_tdata[25:13];
    cmd.x           = in_tdata[49:26];
    cmd.y           = in_tdata[73:50];
    cmd.na          = in_tdata[86:74];
    cmd.nb          = in_tdata[99:87];
    cmd.ta          = in_tdata[112:100];
    cmd.tb          = in_tdata[125:113];
    case (cmd.kind)
      meco_pkg::MODE_NODE:
        keep = (cmd.node_number != '0) && (32'(cmd.node_number) <= NODES);
      meco_pkg::MODE_EDGE, meco_pkg::MODE_REPORT:
        keep = 32'(cmd.edge_index) < EDGES;
      default: keep = 1'b1;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2) && ctl.ready_en;
  assign push      = in_tvalid && in_tready && keep;

  // Two-entry queue
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !ctl.pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && ctl.pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (ctl.pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
  end

  assign q.valid = cnt_r != 2'd0;
  assign q.cmd   = mem_r[rp_r];
endmodule

// ===== design/meco_back.sv =====
`timescale 1ns / 1ps
module meco_back #(
  parameter int NODES     = meco_pkg::NODES_DEF,
  parameter int EDGES     = meco_pkg::EDGES_DEF,
  parameter int TRIANGLES = meco_pkg::TRIS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  meco_pkg::q_head_t                q,
  output meco_pkg::bk_ctl_t                ctl,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [meco_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [meco_pkg::STAT_W-1:0]      out_tuser
);
  localparam int NAW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int TAW = (TRIANGLES > 1) ? $clog2(TRIANGLES) : 1;
  localparam int EW  = $bits(meco_pkg::erec_t);
  localparam int CW  = $bits(meco_pkg::crec_t);
  localparam int XW  = meco_pkg::COORD_W;
  localparam int VW  = meco_pkg::VTX_W;
  localparam int PW  = meco_pkg::PROD_W;

  meco_pkg::st_t    state_r, state_nxt;
  meco_pkg::cmd_t   cmd_r;
  meco_pkg::erec_t  e_r, e_nxt;
  logic             side_r, side_nxt;
  logic             fail_r, fail_nxt;
  logic             ovf_r, ovf_nxt;
  logic             init_done_r, init_done_nxt;
  logic [meco_pkg::TAG_W-1:0] epoch_r, epoch_nxt;
  logic [TAW-1:0]   sweep_r, sweep_nxt;
  logic signed [VW-1:0] v1_r, v1_nxt, v2_r, v2_nxt;
  logic             nv_r, nv_nxt;
  logic signed [XW-1:0] xa_r, ya_r, xb_r, yb_r, xv_r, yv_r;
  logic signed [XW-1:0] xa_nxt, ya_nxt, xb_nxt, yb_nxt, xv_nxt, yv_nxt;
  logic signed [PW-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic             sw_r, sw_nxt;
  meco_pkg::status_t stat_r, stat_nxt;
  logic             ov_r;
  logic [meco_pkg::OUT_DATA_W-1:0] od_r;
  logic [meco_pkg::STAT_W-1:0]     ou_r;
  logic             load_out;

  // Memory ports
  logic             xy_we;
  logic [NAW-1:0]   xy_waddr, xy_raddr;
  logic [XW-1:0]    x_rdata, y_rdata;
  logic             e_we;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [EW-1:0]    e_wdata, e_rdata;
  logic             c_we;
  logic [TAW-1:0]   c_waddr, c_raddr;
  logic [CW-1:0]    c_wdata, c_rdata;

  // Shared decode
  logic signed [meco_pkg::TRI_W-1:0] t_cmd, t_edg;
  logic [31:0]      t_cmd_m1, t_edg_m1, ei32, nn_m1;
  logic             t_cmd_real, t_edg_pos, t_edg_in;
  meco_pkg::crec_t  crd;
  meco_pkg::corner_t cur, add1, add2;
  logic [2:0][meco_pkg::NODE_W-1:0] cmask;
  meco_pkg::opp_t   opp;
  meco_pkg::erec_t  e_rd;
  logic signed [VW-1:0] vsel;
  logic [31:0]      n_a_m1, n_b_m1, n_v_m1;
  logic             n_a_ok, n_b_ok, n_v_ok;
  logic signed [XW:0] d_xv, d_yb, d_xb, d_yv;

  meco_ram #(.W(XW), .D(NODES)) u_xram (
    .clk, .we(xy_we), .waddr(xy_waddr), .wdata(q.cmd.x), .raddr(xy_raddr), .rdata(x_rdata));
  meco_ram #(.W(XW), .D(NODES)) u_yram (
    .clk, .we(xy_we), .waddr(xy_waddr), .wdata(q.cmd.y), .raddr(xy_raddr), .rdata(y_rdata));
  meco_ram #(.W(EW), .D(EDGES)) u_eram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));
  meco_ram #(.W(CW), .D(TRIANGLES)) u_cram (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));

  // Decode of indices, corner words and node addresses
  always_comb begin
    t_cmd      = side_r ? cmd_r.tb : cmd_r.ta;
    t_edg      = side_r ? e_r.tb : e_r.ta;
    t_cmd_m1   = 32'(t_cmd) - 32'd1;
    t_edg_m1   = 32'(t_edg) - 32'd1;
    t_cmd_real = (t_cmd > 0) && (int'(t_cmd) <= TRIANGLES);
    t_edg_pos  = t_edg > 0;
    t_edg_in   = int'(t_edg) <= TRIANGLES;
    ei32       = 32'(q.cmd.edge_index);
    nn_m1      = 32'(q.cmd.node_number) - 32'd1;
    crd        = meco_pkg::crec_t'(c_rdata);
    cur.ovf    = 1'b0;
    cur.cnt    = (crd.tag == epoch_r) ? crd.cnt : '0;
    cur.c      = crd.c;
    add1       = meco_pkg::add_corner(cur, cmd_r.na);
    add2       = meco_pkg::add_corner(add1, cmd_r.nb);
    for (int k = 0; k < 3; k++) begin
      cmask[k] = (meco_pkg::CNT_W'(k) < cur.cnt) ? crd.c[k] : '0;
    end
    opp        = meco_pkg::opposite(cmask, e_r.na, e_r.nb);
    e_rd       = meco_pkg::erec_t'(e_rdata);
    vsel       = (e_r.ta > 0) ? v1_r : v2_r;
    n_a_m1     = 32'(e_r.na) - 32'd1;
    n_b_m1     = 32'(e_r.nb) - 32'd1;
    n_v_m1     = 32'(vsel) - 32'd1;
    n_a_ok     = (e_r.na != '0) && (32'(e_r.na) <= NODES);
    n_b_ok     = (e_r.nb != '0) && (32'(e_r.nb) <= NODES);
    n_v_ok     = (vsel > 0) && (int'(vsel) <= NODES);
    d_xv       = {xv_r[XW-1], xv_r} - {xa_r[XW-1], xa_r};
    d_yb       = {yb_r[XW-1], yb_r} - {ya_r[XW-1], ya_r};
    d_xb       = {xb_r[XW-1], xb_r} - {xa_r[XW-1], xa_r};
    d_yv       = {yv_r[XW-1], yv_r} - {ya_r[XW-1], ya_r};
  end

  assign load_out = !ov_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      meco_pkg::S_SWEEP:
        if (32'(sweep_r) == 32'(TRIANGLES - 1)) state_nxt = meco_pkg::S_IDLE;
      meco_pkg::S_IDLE:
        if (q.valid) begin
          case (q.cmd.kind)
            meco_pkg::MODE_EDGE:   state_nxt = meco_pkg::S_C_RD;
            meco_pkg::MODE_REPORT: state_nxt = meco_pkg::S_E_DAT;
            meco_pkg::MODE_CLEAR:
              if (epoch_r == '1) state_nxt = meco_pkg::S_SWEEP;
            default: state_nxt = meco_pkg::S_IDLE;
          endcase
        end
      meco_pkg::S_C_RD:
        if (t_cmd_real) state_nxt = meco_pkg::S_C_WR;
        else if (side_r) state_nxt = meco_pkg::S_IDLE;
      meco_pkg::S_C_WR:
        if (side_r) state_nxt = meco_pkg::S_IDLE;
        else state_nxt = meco_pkg::S_C_RD;
      meco_pkg::S_E_DAT:
        if (e_rd.ta <= 0 && e_rd.tb <= 0) state_nxt = meco_pkg::S_OUT;
        else state_nxt = meco_pkg::S_T_RD;
      meco_pkg::S_T_RD:
        if (t_edg_pos && t_edg_in) state_nxt = meco_pkg::S_T_DAT;
        else if (side_r) begin
          state_nxt = (fail_r || t_edg_pos) ? meco_pkg::S_OUT : meco_pkg::S_XA;
        end
      meco_pkg::S_T_DAT:
        if (!side_r) state_nxt = meco_pkg::S_T_RD;
        else state_nxt = (fail_r || !opp.found) ? meco_pkg::S_OUT : meco_pkg::S_XA;
      meco_pkg::S_XA:  state_nxt = meco_pkg::S_XB;
      meco_pkg::S_XB:  state_nxt = meco_pkg::S_XV;
      meco_pkg::S_XV:  state_nxt = meco_pkg::S_XL;
      meco_pkg::S_XL:  state_nxt = meco_pkg::S_MUL;
      meco_pkg::S_MUL: state_nxt = meco_pkg::S_CMP;
      meco_pkg::S_CMP: state_nxt = meco_pkg::S_OUT;
      meco_pkg::S_OUT: if (load_out) state_nxt = meco_pkg::S_IDLE;
      default: state_nxt = meco_pkg::S_IDLE;
    endcase
  end

  // Memory and queue control
  always_comb begin
    ctl.pop      = (state_r == meco_pkg::S_IDLE) && q.valid;
    ctl.ready_en = init_done_r;
    xy_we        = 1'b0;
    xy_waddr     = nn_m1[NAW-1:0];
    xy_raddr     = n_a_m1[NAW-1:0];
    e_we         = 1'b0;
    e_waddr      = ei32[EAW-1:0];
    e_wdata      = {q.cmd.na, q.cmd.nb, q.cmd.ta, q.cmd.tb};
    e_raddr      = ei32[EAW-1:0];
    c_we         = 1'b0;
    c_waddr      = t_cmd_m1[TAW-1:0];
    c_wdata      = {epoch_r, add2.cnt, add2.c};
    c_raddr      = t_cmd_m1[TAW-1:0];
    case (state_r)
      meco_pkg::S_SWEEP: begin
        c_we    = 1'b1;
        c_waddr = sweep_r;
        c_wdata = '0;
      end
      meco_pkg::S_IDLE: begin
        xy_we = q.valid && (q.cmd.kind == meco_pkg::MODE_NODE);
        e_we  = q.valid && (q.cmd.kind == meco_pkg::MODE_EDGE);
      end
      meco_pkg::S_C_WR: c_we = 1'b1;
      meco_pkg::S_T_RD: c_raddr = t_edg_m1[TAW-1:0];
      meco_pkg::S_XB:   xy_raddr = n_b_m1[NAW-1:0];
      meco_pkg::S_XV:   xy_raddr = n_v_m1[NAW-1:0];
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    e_nxt = e_r;  side_nxt = side_r;  fail_nxt = fail_r;  ovf_nxt = ovf_r;
    init_done_nxt = init_done_r;  epoch_nxt = epoch_r;  sweep_nxt = sweep_r;
    v1_nxt = v1_r;  v2_nxt = v2_r;  nv_nxt = nv_r;
    xa_nxt = xa_r;  ya_nxt = ya_r;  xb_nxt = xb_r;  yb_nxt = yb_r;
    xv_nxt = xv_r;  yv_nxt = yv_r;  p1_nxt = p1_r;  p2_nxt = p2_r;
    sw_nxt = sw_r;  stat_nxt = stat_r;
    case (state_r)
      meco_pkg::S_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (32'(sweep_r) == 32'(TRIANGLES - 1)) init_done_nxt = 1'b1;
      end
      meco_pkg::S_IDLE: begin
        side_nxt  = 1'b0;
        fail_nxt  = 1'b0;
        sw_nxt    = 1'b0;
        sweep_nxt = '0;
        if (q.valid && q.cmd.kind == meco_pkg::MODE_CLEAR) epoch_nxt = epoch_r + 1'b1;
      end
      meco_pkg::S_C_RD:
        if (!t_cmd_real) side_nxt = 1'b1;
      meco_pkg::S_C_WR: begin
        side_nxt = 1'b1;
        if (add2.ovf) ovf_nxt = 1'b1;
      end
      meco_pkg::S_E_DAT: begin
        e_nxt    = e_rd;
        v1_nxt   = VW'(e_rd.ta);
        v2_nxt   = VW'(e_rd.tb);
        stat_nxt = meco_pkg::ST_NOTRI;
      end
      meco_pkg::S_T_RD:
        if (!(t_edg_pos && t_edg_in)) begin
          side_nxt = 1'b1;
          if (t_edg_pos) begin
            fail_nxt = 1'b1;
            if (side_r) v2_nxt = '0;
            else v1_nxt = '0;
          end
          if (side_r) stat_nxt = meco_pkg::ST_NOCORNER;
        end
      meco_pkg::S_T_DAT: begin
        side_nxt = 1'b1;
        if (!opp.found) fail_nxt = 1'b1;
        if (side_r) v2_nxt = VW'(opp.v);
        else v1_nxt = VW'(opp.v);
        if (side_r) stat_nxt = meco_pkg::ST_NOCORNER;
      end
      meco_pkg::S_XA: nv_nxt = n_a_ok;
      meco_pkg::S_XB: begin
        xa_nxt = nv_r ? x_rdata : '0;
        ya_nxt = nv_r ? y_rdata : '0;
        nv_nxt = n_b_ok;
      end
      meco_pkg::S_XV: begin
        xb_nxt = nv_r ? x_rdata : '0;
        yb_nxt = nv_r ? y_rdata : '0;
        nv_nxt = n_v_ok;
      end
      meco_pkg::S_XL: begin
        xv_nxt = nv_r ? x_rdata : '0;
        yv_nxt = nv_r ? y_rdata : '0;
      end
      meco_pkg::S_MUL: begin
        p1_nxt = d_xv * d_yb;
        p2_nxt = d_xb * d_yv;
      end
      meco_pkg::S_CMP: begin
        sw_nxt   = (e_r.ta > 0) ? (p1_r > p2_r) : (p1_r < p2_r);
        stat_nxt = ovf_r ? meco_pkg::ST_OVF : meco_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= meco_pkg::S_SWEEP;
      ovf_r       <= 1'b0;
      init_done_r <= 1'b0;
      epoch_r     <= '0;
      sweep_r     <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      init_done_r <= init_done_nxt;
      epoch_r     <= (state_r == meco_pkg::S_SWEEP) ? '0 : epoch_nxt;
      sweep_r     <= sweep_nxt;
      if (state_r == meco_pkg::S_OUT && load_out) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.pop) cmd_r <= q.cmd;
    e_r  <= e_nxt;   side_r <= side_nxt;  fail_r <= fail_nxt;
    v1_r <= v1_nxt;  v2_r <= v2_nxt;      nv_r <= nv_nxt;
    xa_r <= xa_nxt;  ya_r <= ya_nxt;      xb_r <= xb_nxt;
    yb_r <= yb_nxt;  xv_r <= xv_nxt;      yv_r <= yv_nxt;
    p1_r <= p1_nxt;  p2_r <= p2_nxt;      sw_r <= sw_nxt;
    stat_r <= stat_nxt;
    if (state_r == meco_pkg::S_OUT && load_out) begin
      od_r <= {4'b0, sw_r,
               sw_r ? v1_r : v2_r, sw_r ? v2_r : v1_r,
               sw_r ? e_r.ta : e_r.tb, sw_r ? e_r.tb : e_r.ta,
               cmd_r.edge_index};
      ou_r <= stat_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
endmodule

// ===== design/mesh_edge_connectivity_orienter_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports
// in_     | slave     | tvalid, tready, tdata (128), tuser (2: mode)
// out_    | master    | tvalid, tready, tdata (72), tuser (2: status)
//
// Node load and clear are done in the idle state; edge load does one corner
// check per side, plus a read-modify-write per real side; report is paced
// by the corner memory reads and the three serial coordinate reads.
// After reset a clearing pass over all TRIANGLES corner entries runs with in_tready low;
// every 256th clear repeats that pass. A two-entry queue and an output
// register let either side stall independently.
module mesh_edge_connectivity_orienter_core #(
  parameter int NODES     = meco_pkg::NODES_DEF,
  parameter int EDGES     = meco_pkg::EDGES_DEF,
  parameter int TRIANGLES = meco_pkg::TRIS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // edge_index, node_number, coord_x, coord_y, end_node_a, end_node_b,
  // side_tri_first, side_tri_second
  input  logic [meco_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode
  input  logic [meco_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // reported_edge, first_triangle, second_triangle, first_vertex,
  // second_vertex, swapped
  output logic [meco_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status
  output logic [meco_pkg::STAT_W-1:0]      out_tuser
);
  meco_pkg::q_head_t q;
  meco_pkg::bk_ctl_t ctl;

  meco_front #(.NODES(NODES), .EDGES(EDGES)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .q, .ctl);

  meco_back #(.NODES(NODES), .EDGES(EDGES), .TRIANGLES(TRIANGLES)) u_back (
    .clk, .rst_n, .q, .ctl, .out_tvalid, .out_tready, .out_tdata, .out_tuser);

  // Clearing pass holds off input right after reset
  a_init_block: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted during clearing pass");

  // No real triangle never swaps
  a_notri_noswap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == meco_pkg::ST_NOTRI |-> !out_tdata[67])
    else $error("swap without a real triangle");

  // A swap only follows a completed orientation test
  a_swap_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67] |->
      (out_tuser == meco_pkg::ST_OK || out_tuser == meco_pkg::ST_OVF))
    else $error("swap with failing status");
endmodule
